// File: hdl/twrtc_pkg.sv
// ----------------------------------------------------------------------------
// twrtc_pkg
// Shared types, codes and conversion helpers for the three-wire RTC master.
// ----------------------------------------------------------------------------
`default_nettype none

package twrtc_pkg;

   // command codes carried in the mode field of a request beat
   localparam logic [2:0] MODE_TICK      = 3'd0;
   localparam logic [2:0] MODE_READ_REG  = 3'd1;
   localparam logic [2:0] MODE_WRITE_REG = 3'd2;
   localparam logic [2:0] MODE_READ_DT   = 3'd3;
   localparam logic [2:0] MODE_WRITE_DT  = 3'd4;

   // configuration register indexes
   localparam int CsrIndexWidth = 8;
   localparam logic [CsrIndexWidth-1:0] CSR_CONTROL_ADDRESS = 8'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_BURST_ADDRESS   = 8'd1;

   localparam logic [7:0] CONTROL_ADDRESS_RESET = 8'd142;
   localparam logic [7:0] BURST_ADDRESS_RESET   = 8'd190;

   localparam logic [7:0] WP_CLEAR_BYTE  = 8'h00;
   localparam logic [7:0] BURST_END_BYTE = 8'h80;

   localparam int DtCount = 7;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_CS_LOW,
      PH_CS_HIGH,
      PH_BIT_LOW,
      PH_BIT_HIGH,
      PH_END
   } phase_type;

   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] reg_address;
      logic [7:0] reg_data;
      logic       sda_in;
      logic [6:0] second;
      logic [6:0] minute;
      logic [6:0] hour;
      logic [6:0] day_of_month;
      logic [6:0] month;
      logic [6:0] weekday;
      logic [6:0] year;
   } req_type;

   typedef struct packed {
      logic       rst_level;
      logic       clock_level;
      logic       data_out;
      logic       data_drive;
      logic       busy_res;
      logic [7:0] read_byte;
      logic [2:0] byte_index;
      logic       byte_valid;
      logic       done_res;
   } rsp_type;

   typedef struct packed {
      logic [7:0] control_address;
      logic [7:0] burst_address;
   } csr_type;

   // binary to BCD; tens by reciprocal multiply (exact for values below 1029)
   function automatic logic [7:0] to_bcd(input logic [6:0] v);
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [6:0]  tens_x10;
      logic [6:0]  units;
      prod     = 15'(v) * 15'd205;
      tens     = prod[14:11];
      tens_x10 = 7'({tens, 3'b000}) + 7'({tens, 1'b0});
      units    = v - tens_x10;
      return {tens, units[3:0]};
   endfunction

   // BCD to binary, tens digit limited to three bits
   function automatic logic [7:0] from_bcd(input logic [7:0] b);
      logic [2:0] tens;
      tens = b[6:4];
      return {2'b00, tens, 3'b000} + {4'b0000, tens, 1'b0} + {4'b0000, b[3:0]};
   endfunction

endpackage

`default_nettype wire

// File: hdl/twrtc_csr.sv
// ----------------------------------------------------------------------------
// twrtc_csr
// Control and burst command byte registers behind the csr write channel.
// ----------------------------------------------------------------------------
`default_nettype none

module twrtc_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [twrtc_pkg::CsrIndexWidth-1:0] csr_index,
   input  wire logic [7:0]                        csr_data,
   output twrtc_pkg::csr_type                     csr_regs
);

   logic [7:0] control_address_ff;
   logic [7:0] burst_address_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         control_address_ff <= twrtc_pkg::CONTROL_ADDRESS_RESET;
         burst_address_ff   <= twrtc_pkg::BURST_ADDRESS_RESET;
      end else if (csr_valid && csr_ready) begin
         // unknown indexes are dropped
         if (csr_index == twrtc_pkg::CSR_CONTROL_ADDRESS) begin
            control_address_ff <= csr_data;
         end
         if (csr_index == twrtc_pkg::CSR_BURST_ADDRESS) begin
            burst_address_ff <= csr_data;
         end
      end
   end

   assign csr_regs.control_address = control_address_ff;
   assign csr_regs.burst_address   = burst_address_ff;

endmodule

`default_nettype wire

// File: hdl/twrtc_in_stage.sv
// ----------------------------------------------------------------------------
// twrtc_in_stage
// Request input register; holds one beat until the engine takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module twrtc_in_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire twrtc_pkg::req_type req_data,
   output logic                   item_valid,
   output twrtc_pkg::req_type     item_data,
   input  wire logic              item_take
);

   logic               valid_ff;
   logic               valid_in;
   twrtc_pkg::req_type data_ff;
   logic               load;

   assign req_stall = valid_ff && !item_take;
   assign load      = req_valid && !req_stall;
   assign valid_in  = load || (valid_ff && !item_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= req_data;
      end
   end

   assign item_valid = valid_ff;
   assign item_data  = data_ff;

endmodule

`default_nettype wire

// File: hdl/twrtc_engine.sv
// ----------------------------------------------------------------------------
// twrtc_engine
// Bus phase sequencer, shift datapath and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module twrtc_engine (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire twrtc_pkg::csr_type csr_regs,
   input  wire logic              item_valid,
   input  wire twrtc_pkg::req_type item_data,
   output logic                   item_take,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output twrtc_pkg::rsp_type     rsp_data
);

   twrtc_pkg::phase_type phase_ff, phase_in;
   logic [2:0] kind_ff, kind_in;
   logic [2:0] bit_cnt_ff, bit_cnt_in;
   logic [3:0] byte_cnt_ff, byte_cnt_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] addr_ff, addr_in;
   logic [7:0] wdata_ff, wdata_in;
   logic       pend_ff, pend_in;
   logic       rst_ff, rst_in;
   logic       clk_ff, clk_in;
   logic       dout_ff, dout_in;
   logic       drive_ff, drive_in;
   logic [6:0] store_ff [twrtc_pkg::DtCount];
   logic       store_load;
   logic       rsp_valid_ff;
   twrtc_pkg::rsp_type rsp_ff, rsp_in;

   logic       is_cmd;
   logic       in_burst;
   logic       rd_now;
   logic       last_bit;
   logic       last_byte;
   logic [3:0] byte_next;
   logic [7:0] shift_hi;
   logic [7:0] load_val;
   logic [3:0] load_idx;
   logic       load_rd;
   logic [2:0] store_sel;

   assign item_take = item_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      unique case (item_data.mode) inside
         twrtc_pkg::MODE_READ_REG, twrtc_pkg::MODE_WRITE_REG,
         twrtc_pkg::MODE_READ_DT, twrtc_pkg::MODE_WRITE_DT: is_cmd = 1'b1;
         default: is_cmd = 1'b0;
      endcase
   end

   assign in_burst = (kind_ff == twrtc_pkg::MODE_READ_DT) ||
                     ((kind_ff == twrtc_pkg::MODE_WRITE_DT) && !pend_ff);
   assign rd_now   = ((kind_ff == twrtc_pkg::MODE_READ_REG) && (byte_cnt_ff == 4'd1)) ||
                     ((kind_ff == twrtc_pkg::MODE_READ_DT) && (byte_cnt_ff != 4'd0));
   assign last_bit  = (bit_cnt_ff == 3'd7);
   assign byte_next = byte_cnt_ff + 4'd1;
   assign last_byte = byte_next >= (in_burst ? 4'd9 : 4'd2);
   assign shift_hi  = rd_now ? shift_ff : {1'b0, shift_ff[7:1]};

   // next byte to send: index 0 from the command bytes, later from data
   assign load_idx  = (phase_ff == twrtc_pkg::PH_BIT_HIGH) ? byte_next : 4'd0;
   assign load_rd   = ((kind_ff == twrtc_pkg::MODE_READ_REG) && (load_idx == 4'd1)) ||
                      ((kind_ff == twrtc_pkg::MODE_READ_DT) && (load_idx != 4'd0));
   assign store_sel = load_idx[2:0] - 3'd1;

   always_comb begin
      if (load_rd) begin
         load_val = 8'h00;
      end else if (kind_ff == twrtc_pkg::MODE_READ_DT) begin
         load_val = csr_regs.burst_address | 8'h01;
      end else if (in_burst) begin
         if (load_idx == 4'd0) begin
            load_val = csr_regs.burst_address;
         end else if (load_idx <= 4'd7) begin
            load_val = twrtc_pkg::to_bcd(store_ff[store_sel]);
         end else begin
            load_val = twrtc_pkg::BURST_END_BYTE;
         end
      end else if (load_idx == 4'd0) begin
         load_val = (kind_ff == twrtc_pkg::MODE_READ_REG) ? (addr_ff | 8'h01) : addr_ff;
      end else begin
         load_val = wdata_ff;
      end
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (item_take) begin
         if (is_cmd) begin
            if (phase_ff == twrtc_pkg::PH_IDLE) begin
               phase_in = twrtc_pkg::PH_CS_LOW;
            end
         end else begin
            unique case (phase_ff)
               twrtc_pkg::PH_IDLE:     phase_in = twrtc_pkg::PH_IDLE;
               twrtc_pkg::PH_CS_LOW:   phase_in = twrtc_pkg::PH_CS_HIGH;
               twrtc_pkg::PH_CS_HIGH:  phase_in = twrtc_pkg::PH_BIT_LOW;
               twrtc_pkg::PH_BIT_LOW:  phase_in = twrtc_pkg::PH_BIT_HIGH;
               twrtc_pkg::PH_BIT_HIGH: begin
                  if (last_bit && last_byte) begin
                     phase_in = twrtc_pkg::PH_END;
                  end else begin
                     phase_in = twrtc_pkg::PH_BIT_LOW;
                  end
               end
               twrtc_pkg::PH_END: begin
                  phase_in = pend_ff ? twrtc_pkg::PH_CS_LOW : twrtc_pkg::PH_IDLE;
               end
               default: phase_in = twrtc_pkg::PH_IDLE;
            endcase
         end
      end
   end

   // datapath and pin levels
   always_comb begin
      kind_in     = kind_ff;
      bit_cnt_in  = bit_cnt_ff;
      byte_cnt_in = byte_cnt_ff;
      shift_in    = shift_ff;
      addr_in     = addr_ff;
      wdata_in    = wdata_ff;
      pend_in     = pend_ff;
      rst_in      = rst_ff;
      clk_in      = clk_ff;
      dout_in     = dout_ff;
      drive_in    = drive_ff;
      store_load  = 1'b0;
      rsp_in.read_byte  = 8'h00;
      rsp_in.byte_index = 3'd0;
      rsp_in.byte_valid = 1'b0;
      rsp_in.done_res   = 1'b0;
      if (item_take) begin
         if (is_cmd) begin
            if (phase_ff == twrtc_pkg::PH_IDLE) begin
               kind_in     = item_data.mode;
               bit_cnt_in  = 3'd0;
               byte_cnt_in = 4'd0;
               shift_in    = 8'h00;
               if (item_data.mode == twrtc_pkg::MODE_WRITE_DT) begin
                  // clear write protect first, burst follows
                  addr_in    = csr_regs.control_address;
                  wdata_in   = twrtc_pkg::WP_CLEAR_BYTE;
                  pend_in    = 1'b1;
                  store_load = 1'b1;
               end else begin
                  addr_in  = item_data.reg_address;
                  wdata_in = item_data.reg_data;
                  pend_in  = 1'b0;
               end
            end
         end else begin
            unique case (phase_ff)
               twrtc_pkg::PH_IDLE: begin
               end
               twrtc_pkg::PH_CS_LOW: begin
                  rst_in   = 1'b0;
                  clk_in   = 1'b0;
                  dout_in  = 1'b0;
                  drive_in = 1'b1;
               end
               twrtc_pkg::PH_CS_HIGH: begin
                  rst_in      = 1'b1;
                  clk_in      = 1'b0;
                  byte_cnt_in = 4'd0;
                  bit_cnt_in  = 3'd0;
                  shift_in    = load_val;
               end
               twrtc_pkg::PH_BIT_LOW: begin
                  clk_in = 1'b0;
                  if (rd_now) begin
                     drive_in = 1'b0;
                     dout_in  = 1'b0;
                     shift_in = {item_data.sda_in, shift_ff[7:1]};
                  end else begin
                     drive_in = 1'b1;
                     dout_in  = shift_ff[0];
                  end
               end
               twrtc_pkg::PH_BIT_HIGH: begin
                  clk_in = 1'b1;
                  if (last_bit) begin
                     if ((kind_ff == twrtc_pkg::MODE_READ_REG) && (byte_cnt_ff == 4'd1)) begin
                        rsp_in.read_byte  = shift_hi;
                        rsp_in.byte_valid = 1'b1;
                     end else if ((kind_ff == twrtc_pkg::MODE_READ_DT) &&
                                  (byte_cnt_ff >= 4'd1) && (byte_cnt_ff <= 4'd7)) begin
                        rsp_in.read_byte  = twrtc_pkg::from_bcd(shift_hi);
                        rsp_in.byte_index = byte_cnt_ff[2:0] - 3'd1;
                        rsp_in.byte_valid = 1'b1;
                     end
                     bit_cnt_in  = 3'd0;
                     byte_cnt_in = byte_next;
                     shift_in    = last_byte ? shift_hi : load_val;
                  end else begin
                     bit_cnt_in = bit_cnt_ff + 3'd1;
                     shift_in   = shift_hi;
                  end
               end
               twrtc_pkg::PH_END: begin
                  rst_in   = 1'b0;
                  dout_in  = 1'b0;
                  drive_in = 1'b1;
                  if (pend_ff) begin
                     pend_in = 1'b0;
                  end else begin
                     rsp_in.done_res = 1'b1;
                     kind_in         = twrtc_pkg::MODE_TICK;
                  end
               end
               default: begin
               end
            endcase
         end
      end
      rsp_in.rst_level   = rst_in;
      rsp_in.clock_level = clk_in;
      rsp_in.data_out    = dout_in;
      rsp_in.data_drive  = drive_in;
      rsp_in.busy_res    = (phase_in != twrtc_pkg::PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= twrtc_pkg::PH_IDLE;
         kind_ff      <= twrtc_pkg::MODE_TICK;
         bit_cnt_ff   <= 3'd0;
         byte_cnt_ff  <= 4'd0;
         pend_ff      <= 1'b0;
         rst_ff       <= 1'b0;
         clk_ff       <= 1'b0;
         dout_ff      <= 1'b0;
         drive_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         kind_ff      <= kind_in;
         bit_cnt_ff   <= bit_cnt_in;
         byte_cnt_ff  <= byte_cnt_in;
         pend_ff      <= pend_in;
         rst_ff       <= rst_in;
         clk_ff       <= clk_in;
         dout_ff      <= dout_in;
         drive_ff     <= drive_in;
         // hold a result until the sink takes it
         if (item_take) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      addr_ff  <= addr_in;
      wdata_ff <= wdata_in;
      if (item_take) begin
         rsp_ff <= rsp_in;
      end
      if (store_load) begin
         store_ff[0] <= item_data.second;
         store_ff[1] <= item_data.minute;
         store_ff[2] <= item_data.hour;
         store_ff[3] <= item_data.day_of_month;
         store_ff[4] <= item_data.month;
         store_ff[5] <= item_data.weekday;
         store_ff[6] <= item_data.year;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// File: hdl/three_wire_rtc_serial_master.sv
// ----------------------------------------------------------------------------
// three_wire_rtc_serial_master
// Three-wire serial real-time-clock bus master, one pin phase per tick beat.
// ----------------------------------------------------------------------------
// Every request beat yields exactly one response beat. A command beat
// (register read/write, datetime burst read/write) only latches the job;
// each following tick beat moves the bus by one pin phase and the response
// carries the resulting chip select, clock and data levels plus any byte
// completed on that phase. Commands that arrive while a job runs are dropped.
// Throughput is one beat per clock while rsp_stall is low: the whole phase
// update is a single pass from the request register to the response
// register, and the phase state registers close their loop in that pass. A
// request beat waits in the input register until the engine takes it, and its
// response is then registered. Write the csr registers only while idle.
`default_nettype none

module three_wire_rtc_serial_master (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire twrtc_pkg::req_type                req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output twrtc_pkg::rsp_type                     rsp_data,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [twrtc_pkg::CsrIndexWidth-1:0] csr_index,
   input  wire logic [7:0]                        csr_data
);

   twrtc_pkg::csr_type csr_regs;
   twrtc_pkg::req_type item_data;
   logic               item_valid;
   logic               item_take;

   twrtc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .csr_regs  (csr_regs)
   );

   twrtc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .item_valid (item_valid),
      .item_data  (item_data),
      .item_take  (item_take)
   );

   twrtc_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .csr_regs   (csr_regs),
      .item_valid (item_valid),
      .item_data  (item_data),
      .item_take  (item_take),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

// File: test/rtc_bus_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_bus_checker
// Watches the request, response and csr channels of the three-wire RTC
// master, keeps its own pin-phase model of the bus, predicts one response
// per accepted request beat and compares every response beat field by field.
// ----------------------------------------------------------------------------

module rtc_bus_checker
   import twrtc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_stall,
   input  req_type         req_data,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_stall,
   input  rsp_type         rsp_data,
   input  wire logic       csr_valid,
   input  wire logic       csr_ready,
   input  wire logic [7:0] csr_index,
   input  wire logic [7:0] csr_data,
   output int              fail_count,
   output int              pending_count,
   output logic            model_busy
);

   // model of the bus master
   phase_type  ph;
   logic [2:0] kind;
   logic [2:0] bit_cnt;
   logic [3:0] byte_cnt;
   logic [7:0] shreg;
   logic [7:0] addr_hold;
   logic [7:0] data_hold;
   logic [6:0] dt_vals [DtCount];
   logic       second_pending;
   logic       cs_lvl, clk_lvl, dout_lvl, drive_lvl;
   logic [7:0] ctrl_addr;
   logic [7:0] burst_addr;

   rsp_type    expected_rsps [$];
   rsp_type    want;
   int         mismatch_total = 0;

   assign fail_count    = mismatch_total;
   assign pending_count = expected_rsps.size();
   assign model_busy    = (ph != PH_IDLE);

   function automatic logic [7:0] bcd_of(input logic [6:0] v);
      logic [3:0] tens;
      logic [3:0] units;
      tens  = 4'(v / 7'd10);
      units = 4'(v % 7'd10);
      return {tens, units};
   endfunction

   function automatic logic [7:0] bin_of(input logic [7:0] b);
      return 8'(b[6:4]) * 8'd10 + 8'(b[3:0]);
   endfunction

   function automatic logic burst_txn();
      return kind == MODE_READ_DT || (kind == MODE_WRITE_DT && !second_pending);
   endfunction

   function automatic logic sampling_now();
      if (kind == MODE_READ_REG) return byte_cnt == 4'd1;
      if (kind == MODE_READ_DT) return byte_cnt >= 4'd1;
      return 1'b0;
   endfunction

   function automatic logic [7:0] next_byte(input int idx);
      if (sampling_now()) return 8'h00;
      if (kind == MODE_READ_DT) return burst_addr | 8'h01;
      if (kind == MODE_WRITE_DT && !second_pending) begin
         if (idx == 0) return burst_addr;
         if (idx <= DtCount) return bcd_of(dt_vals[idx-1]);
         return BURST_END_BYTE;
      end
      if (idx == 0) return (kind == MODE_READ_REG) ? (addr_hold | 8'h01) : addr_hold;
      return data_hold;
   endfunction

   function automatic void reset_model();
      ctrl_addr      = CONTROL_ADDRESS_RESET;
      burst_addr     = BURST_ADDRESS_RESET;
      ph             = PH_IDLE;
      kind           = MODE_TICK;
      bit_cnt        = '0;
      byte_cnt       = '0;
      shreg          = '0;
      addr_hold      = '0;
      data_hold      = '0;
      second_pending = 1'b0;
      foreach (dt_vals[i]) dt_vals[i] = '0;
      cs_lvl = 1'b0; clk_lvl = 1'b0; dout_lvl = 1'b0; drive_lvl = 1'b1;
   endfunction

   // advance the model by one request beat and return the response it causes
   function automatic rsp_type step_bus(input req_type r);
      rsp_type o;
      o = '0;
      if (r.mode >= MODE_READ_REG && r.mode <= MODE_WRITE_DT) begin
         // commands while busy are dropped
         if (ph == PH_IDLE) begin
            kind           = r.mode;
            second_pending = 1'b0;
            addr_hold      = r.reg_address;
            data_hold      = r.reg_data;
            if (r.mode == MODE_WRITE_DT) begin
               addr_hold      = ctrl_addr;
               data_hold      = WP_CLEAR_BYTE;
               second_pending = 1'b1;
               dt_vals[0] = r.second;
               dt_vals[1] = r.minute;
               dt_vals[2] = r.hour;
               dt_vals[3] = r.day_of_month;
               dt_vals[4] = r.month;
               dt_vals[5] = r.weekday;
               dt_vals[6] = r.year;
            end
            bit_cnt  = '0;
            byte_cnt = '0;
            shreg    = '0;
            ph       = PH_CS_LOW;
         end
      end else begin
         case (ph)
            PH_CS_LOW: begin
               cs_lvl = 1'b0; clk_lvl = 1'b0; dout_lvl = 1'b0; drive_lvl = 1'b1;
               ph = PH_CS_HIGH;
            end
            PH_CS_HIGH: begin
               cs_lvl   = 1'b1;
               clk_lvl  = 1'b0;
               byte_cnt = '0;
               bit_cnt  = '0;
               shreg    = next_byte(0);
               ph       = PH_BIT_LOW;
            end
            PH_BIT_LOW: begin
               clk_lvl = 1'b0;
               if (sampling_now()) begin
                  drive_lvl = 1'b0;
                  dout_lvl  = 1'b0;
                  shreg     = {r.sda_in, shreg[7:1]};
               end else begin
                  drive_lvl = 1'b1;
                  dout_lvl  = shreg[0];
               end
               ph = PH_BIT_HIGH;
            end
            PH_BIT_HIGH: begin
               clk_lvl = 1'b1;
               if (!sampling_now()) shreg = shreg >> 1;
               if (bit_cnt == 3'd7) begin
                  if (kind == MODE_READ_REG && byte_cnt == 4'd1) begin
                     o.read_byte  = shreg;
                     o.byte_valid = 1'b1;
                  end else if (kind == MODE_READ_DT && byte_cnt >= 4'd1
                               && byte_cnt <= 4'(DtCount)) begin
                     o.read_byte  = bin_of(shreg);
                     o.byte_index = 3'(byte_cnt - 4'd1);
                     o.byte_valid = 1'b1;
                  end
                  bit_cnt  = '0;
                  byte_cnt = byte_cnt + 4'd1;
                  if (byte_cnt >= (burst_txn() ? 4'd9 : 4'd2)) begin
                     ph = PH_END;
                  end else begin
                     shreg = next_byte(int'(byte_cnt));
                     ph    = PH_BIT_LOW;
                  end
               end else begin
                  bit_cnt = bit_cnt + 3'd1;
                  ph      = PH_BIT_LOW;
               end
            end
            PH_END: begin
               cs_lvl = 1'b0; dout_lvl = 1'b0; drive_lvl = 1'b1;
               // the datetime write chains its burst after the protect clear
               if (second_pending) begin
                  second_pending = 1'b0;
                  ph = PH_CS_LOW;
               end else begin
                  o.done_res = 1'b1;
                  kind = MODE_TICK;
                  ph   = PH_IDLE;
               end
            end
            PH_IDLE: ;
            default: ph = PH_IDLE;
         endcase
      end
      o.rst_level   = cs_lvl;
      o.clock_level = clk_lvl;
      o.data_out    = dout_lvl;
      o.data_drive  = drive_lvl;
      o.busy_res    = (ph != PH_IDLE);
      return o;
   endfunction

   function automatic void check_field(input string name, input logic [7:0] exp_v,
                                       input logic [7:0] act_v);
      if (act_v !== exp_v) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
         mismatch_total++;
      end
   endfunction

   initial reset_model();

   always @(posedge clock) begin
      if (reset) begin
         reset_model();
         expected_rsps.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response beat, expected none actual %h",
                        $time, rsp_data);
               mismatch_total++;
            end else begin
               want = expected_rsps.pop_front();
               check_field("rst_level",   want.rst_level,   rsp_data.rst_level);
               check_field("clock_level", want.clock_level, rsp_data.clock_level);
               check_field("data_out",    want.data_out,    rsp_data.data_out);
               check_field("data_drive",  want.data_drive,  rsp_data.data_drive);
               check_field("busy_res",    want.busy_res,    rsp_data.busy_res);
               check_field("read_byte",   want.read_byte,   rsp_data.read_byte);
               check_field("byte_index",  want.byte_index,  rsp_data.byte_index);
               check_field("byte_valid",  want.byte_valid,  rsp_data.byte_valid);
               check_field("done_res",    want.done_res,    rsp_data.done_res);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CONTROL_ADDRESS: ctrl_addr  = csr_data;
               CSR_BURST_ADDRESS:   burst_addr = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) expected_rsps.push_back(step_bus(req_data));
      end
   end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the three-wire RTC master: directed commands with
// extreme fields, then random well-formed transactions mixed with ignored
// commands, stray ticks and cut-short sequences under several csr settings.
// ----------------------------------------------------------------------------

module tb_top;
   import twrtc_pkg::*;

   localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
   localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;
   localparam int SDA_LOW  = 0;
   localparam int SDA_HIGH = 1;
   localparam int SDA_RAND = 2;
   localparam int REG_TXN_TICKS   = 35;
   localparam int BURST_TXN_TICKS = 147;
   localparam int DT_WRITE_TICKS  = 182;
   localparam int HOLD_CYCLES     = 400;
   localparam int CYCLE_LIMIT     = 1_000_000;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   req_type    req_data;
   logic       rsp_valid;
   logic       rsp_stall;
   rsp_type    rsp_data;
   logic       csr_valid;
   logic       csr_ready;
   logic [7:0] csr_index;
   logic [7:0] csr_data;

   int   fail_count;
   int   pending_count;
   logic model_busy;

   int   beats_sent = 0;
   int   cycles = 0;
   logic calm = 1'b0;
   logic hold_request = 1'b0;

   three_wire_rtc_serial_master u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   rtc_bus_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .model_busy    (model_busy)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: cycle limit reached", $time);
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic req_type random_req();
      logic [95:0] raw;
      raw = {$urandom, $urandom, $urandom};
      return raw[$bits(req_type)-1:0];
   endfunction

   function automatic logic [6:0] dt_value();
      if ($urandom_range(0, 5) == 0) return 7'($urandom_range(100, 127));
      return 7'($urandom_range(0, 99));
   endfunction

   function automatic req_type tick_item(input int sda_sel);
      req_type r;
      r = random_req();
      if ($urandom_range(0, 15) == 0)
         r.mode = 3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
      else
         r.mode = MODE_TICK;
      if (sda_sel == SDA_LOW) r.sda_in = 1'b0;
      else if (sda_sel == SDA_HIGH) r.sda_in = 1'b1;
      return r;
   endfunction

   function automatic req_type cmd_item(input logic [2:0] mode);
      req_type r;
      r = random_req();
      r.mode         = mode;
      r.second       = dt_value();
      r.minute       = dt_value();
      r.hour         = dt_value();
      r.day_of_month = dt_value();
      r.month        = dt_value();
      r.weekday      = dt_value();
      r.year         = dt_value();
      return r;
   endfunction

   function automatic int txn_ticks(input logic [2:0] mode);
      if (mode == MODE_READ_DT) return BURST_TXN_TICKS;
      if (mode == MODE_WRITE_DT) return DT_WRITE_TICKS;
      return REG_TXN_TICKS;
   endfunction

   // entered and left at a falling edge; valid stays high between beats unless a random gap is inserted
   task automatic send_beat(input req_type item);
      int gap;
      if (!calm && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 19);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic run_cmd(input req_type cmd, input int sda_sel, input int ticks,
                          input bit noisy);
      send_beat(cmd);
      repeat (ticks) begin
         // a command mid-transaction must be dropped
         if (noisy && $urandom_range(0, 49) == 0)
            send_beat(cmd_item(3'($urandom_range(MODE_READ_REG, MODE_WRITE_DT))));
         send_beat(tick_item(sda_sel));
      end
   endtask

   task automatic random_phase(input int goal);
      int         start;
      int         n;
      int         pick;
      logic [2:0] mode;
      start = beats_sent;
      while (beats_sent - start < goal) begin
         mode = 3'($urandom_range(MODE_READ_REG, MODE_WRITE_DT));
         n    = txn_ticks(mode);
         pick = $urandom_range(0, 9);
         if (pick == 0) n = n - $urandom_range(1, 30);
         else if (pick == 1) n = n + $urandom_range(1, 6);
         run_cmd(cmd_item(mode), SDA_RAND, n, 1'b1);
      end
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
   endtask

   // finish the running transaction, drain, then program both registers
   task automatic settle_and_set(input logic [7:0] ctrl, input logic [7:0] burst);
      while (model_busy) send_beat(tick_item(SDA_RAND));
      wait_for_results();
      repeat (4) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= CSR_CONTROL_ADDRESS;
      csr_data  <= ctrl;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_index <= CSR_BURST_ADDRESS;
      csr_data  <= burst;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // receiver: random stall bursts, one long hold-off on request
   initial begin
      int n;
      rsp_stall = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
            rsp_stall <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 19);
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      req_type item;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      reset     = 1'b1;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // idle ticks, including the spare mode codes
      send_beat(tick_item(SDA_RAND));
      for (int m = MODE_SPARE_FIRST; m <= MODE_SPARE_LAST; m++) begin
         item = tick_item(SDA_RAND);
         item.mode = 3'(m);
         send_beat(item);
      end

      // register read of all ones, with a command dropped while busy
      item = cmd_item(MODE_READ_REG);
      item.reg_address = 8'hFF;
      send_beat(item);
      repeat (10) send_beat(tick_item(SDA_HIGH));
      send_beat(cmd_item(MODE_WRITE_DT));
      repeat (REG_TXN_TICKS - 10) send_beat(tick_item(SDA_HIGH));

      item = cmd_item(MODE_WRITE_REG);
      item.reg_address = 8'h00;
      item.reg_data    = 8'hFF;
      run_cmd(item, SDA_LOW, REG_TXN_TICKS, 1'b0);

      run_cmd(cmd_item(MODE_READ_DT), SDA_HIGH, BURST_TXN_TICKS, 1'b0);

      // datetime values at and beyond the two-digit range
      item = cmd_item(MODE_WRITE_DT);
      item.second       = 7'd127;
      item.minute       = 7'd0;
      item.hour         = 7'd99;
      item.day_of_month = 7'd100;
      item.month        = 7'd1;
      item.weekday      = 7'd110;
      item.year         = 7'd9;
      run_cmd(item, SDA_RAND, DT_WRITE_TICKS, 1'b0);

      run_cmd(cmd_item(MODE_READ_DT), SDA_LOW, BURST_TXN_TICKS, 1'b0);

      settle_and_set(8'h00, 8'h00);
      random_phase(260);

      settle_and_set(8'hFF, 8'hFF);
      hold_request = 1'b1;
      random_phase(260);

      settle_and_set(8'($urandom), 8'($urandom));
      random_phase(60);
      wait_for_results();
      random_phase(200);

      settle_and_set(8'($urandom), 8'($urandom));
      calm = 1'b1;
      random_phase(260);

      wait_for_results();
      repeat (8) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
